### rtl/core/gnos_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package gnos_pkg;

    // Stages in one octave cell.
    localparam int CELL_LAT = 16;

    // Quotient bits of the normalizing divider.
    localparam int QUO_W = 16;

    // Fixed formats of the noise datapath.
    localparam int FRAC_W = 16;                 // cell fraction, Q0.16
    localparam int CORD_W = FRAC_W + 2;         // corner offset, t or t - 1
    localparam int GRAD_W = FRAC_W + 3;         // gradient term and blends
    localparam int DIFF_W = GRAD_W + 1;
    localparam int PROD_W = DIFF_W + FRAC_W + 1;
    localparam int SCL_PROD_W = GRAD_W + 18;

    localparam logic [17:0] SCALE_Q16 = 18'd68157;   // 1.04 in Q.16

    localparam logic [15:0] AMP_ONE = 16'd32768;     // 1.0 in Q.15

    localparam logic signed [QUO_W:0] NOISE_MAX = 17'sd32767;
    localparam logic signed [QUO_W:0] NOISE_MIN = -17'sd32768;

    // Configuration register indexes.
    localparam logic [1:0] CFG_OCTAVES = 2'd0;
    localparam logic [1:0] CFG_PERSIST = 2'd1;

    localparam logic [3:0]  OCTAVES_RST = 4'd1;
    localparam logic [15:0] PERSIST_RST = 16'd16384;

    localparam logic [7:0] PERM [256] = '{
        8'd6, 8'd119, 8'd52, 8'd224, 8'd161, 8'd63, 8'd89, 8'd255, 8'd93, 8'd178,
        8'd68, 8'd30, 8'd236, 8'd127, 8'd183, 8'd104, 8'd86, 8'd232, 8'd133, 8'd233,
        8'd220, 8'd41, 8'd205, 8'd144, 8'd58, 8'd67, 8'd191, 8'd149, 8'd96, 8'd231,
        8'd97, 8'd209, 8'd71, 8'd49, 8'd113, 8'd2, 8'd120, 8'd235, 8'd166, 8'd223,
        8'd46, 8'd11, 8'd216, 8'd158, 8'd15, 8'd44, 8'd112, 8'd130, 8'd27, 8'd25,
        8'd136, 8'd69, 8'd196, 8'd122, 8'd8, 8'd84, 8'd227, 8'd22, 8'd143, 8'd101,
        8'd3, 8'd51, 8'd32, 8'd64, 8'd253, 8'd13, 8'd225, 8'd56, 8'd201, 8'd230,
        8'd107, 8'd140, 8'd137, 8'd204, 8'd254, 8'd74, 8'd87, 8'd19, 8'd176, 8'd165,
        8'd66, 8'd17, 8'd207, 8'd249, 8'd197, 8'd211, 8'd54, 8'd123, 8'd128, 8'd105,
        8'd202, 8'd252, 8'd239, 8'd121, 8'd181, 8'd186, 8'd40, 8'd208, 8'd146, 8'd251,
        8'd210, 8'd92, 8'd138, 8'd79, 8'd162, 8'd29, 8'd91, 8'd83, 8'd106, 8'd43,
        8'd244, 8'd21, 8'd215, 8'd141, 8'd47, 8'd95, 8'd7, 8'd73, 8'd152, 8'd241,
        8'd42, 8'd31, 8'd134, 8'd117, 8'd156, 8'd85, 8'd237, 8'd124, 8'd172, 8'd23,
        8'd175, 8'd245, 8'd33, 8'd238, 8'd90, 8'd188, 8'd203, 8'd187, 8'd1, 8'd37,
        8'd38, 8'd14, 8'd110, 8'd200, 8'd24, 8'd229, 8'd35, 8'd234, 8'd217, 8'd16,
        8'd206, 8'd214, 8'd174, 8'd60, 8'd222, 8'd154, 8'd111, 8'd116, 8'd12, 8'd212,
        8'd102, 8'd169, 8'd177, 8'd28, 8'd228, 8'd194, 8'd147, 8'd192, 8'd242, 8'd61,
        8'd193, 8'd240, 8'd168, 8'd72, 8'd213, 8'd98, 8'd45, 8'd103, 8'd114, 8'd53,
        8'd26, 8'd62, 8'd129, 8'd248, 8'd34, 8'd247, 8'd50, 8'd153, 8'd135, 8'd226,
        8'd246, 8'd88, 8'd199, 8'd151, 8'd9, 8'd65, 8'd189, 8'd157, 8'd198, 8'd125,
        8'd132, 8'd70, 8'd173, 8'd185, 8'd180, 8'd76, 8'd221, 8'd115, 8'd81, 8'd80,
        8'd219, 8'd39, 8'd145, 8'd243, 8'd150, 8'd179, 8'd148, 8'd82, 8'd163, 8'd100,
        8'd48, 8'd160, 8'd36, 8'd164, 8'd5, 8'd118, 8'd155, 8'd99, 8'd75, 8'd170,
        8'd18, 8'd131, 8'd167, 8'd139, 8'd77, 8'd190, 8'd94, 8'd195, 8'd218, 8'd78,
        8'd57, 8'd159, 8'd4, 8'd10, 8'd109, 8'd184, 8'd182, 8'd171, 8'd250, 8'd59,
        8'd142, 8'd108, 8'd20, 8'd55, 8'd126, 8'd0
    };

    // Dot product of the edge gradient that h selects with the corner offset.
    function automatic logic signed [GRAD_W-1:0] grad(
        input logic [3:0]               h,
        input logic signed [CORD_W-1:0] x,
        input logic signed [CORD_W-1:0] y,
        input logic signed [CORD_W-1:0] z
    );
        logic signed [GRAD_W-1:0] u;
        logic signed [GRAD_W-1:0] v;
        u = (h < 4'd8) ? GRAD_W'(x) : GRAD_W'(y);
        if (h < 4'd4)
            v = GRAD_W'(y);
        else if (h == 4'd12 || h == 4'd14)
            v = GRAD_W'(x);
        else
            v = GRAD_W'(z);
        if (h[0])
            u = -u;
        if (h[1])
            v = -v;
        return u + v;
    endfunction

endpackage

`default_nettype wire

### rtl/core/gradient_noise_octave_sum.sv
`timescale 1ns / 1ps
`default_nettype none

// Fractal 3D gradient noise. A word (coord_x, coord_y, coord_z, signed fixed
// point with FRACTION_BITS fraction bits) is taken on every clock at which
// start is high; busy stays low, so a new word may follow every cycle with
// no gaps. Each word yields one noise_value (signed Q2.14, saturated), shown
// for exactly one cycle with done high. The word passes an input register,
// then the row of octave cells, one sixteen-stage cell per possible octave,
// then a sixteen-step pipelined divider that normalizes by the summed
// amplitude, then an output register; words come out in the order they went
// in. The receiver cannot stall the result, so it must take done words as
// they appear.
// Configuration: index 0 sets octave_count (zero acts as one, values above
// MAX_OCTAVES act as MAX_OCTAVES), index 1 sets persistence (unsigned Q1.15).
// Other indexes are ignored. Write them only when no word is in flight.
module gradient_noise_octave_sum #(
    parameter int MAX_OCTAVES   = 8,
    parameter int FRACTION_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] coord_x,
    input  logic signed [31:0] coord_y,
    input  logic signed [31:0] coord_z,
    output logic               done,
    output logic signed [15:0] noise_value,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data
);
    import gnos_pkg::*;

    localparam int AMP_W     = 16 + MAX_OCTAVES;
    localparam int ASUM_W    = 17 + MAX_OCTAVES;
    localparam int TOT_W     = 36 + MAX_OCTAVES;
    localparam int DEN_W     = ASUM_W + 2;
    localparam int CNT_W     = $clog2(MAX_OCTAVES + 1);
    localparam int TOTAL_LAT = 2 + CELL_LAT * MAX_OCTAVES + QUO_W;

    // Configuration registers.
    logic [3:0]         octave_count_reg;
    logic [15:0]        persistence_reg;
    logic [4:0]         oc_wide;
    logic [CNT_W-1:0]   n_oct;

    // Input word register.
    logic               in_vld_reg;
    logic signed [31:0] cx_in_reg;
    logic signed [31:0] cy_in_reg;
    logic signed [31:0] cz_in_reg;

    // Octave cell row.
    logic               oct_vld  [MAX_OCTAVES+1];
    logic signed [31:0] oct_cx   [MAX_OCTAVES+1];
    logic signed [31:0] oct_cy   [MAX_OCTAVES+1];
    logic signed [31:0] oct_cz   [MAX_OCTAVES+1];
    logic signed [TOT_W-1:0] oct_tot [MAX_OCTAVES+1];
    logic [ASUM_W-1:0]  oct_asum [MAX_OCTAVES+1];
    logic [AMP_W-1:0]   oct_amp  [MAX_OCTAVES+1];

    // Divider row; entry 0 feeds the step for the top quotient bit.
    logic               div_vld  [QUO_W+1];
    logic               div_sign [QUO_W+1];
    logic [TOT_W-1:0]   div_rem  [QUO_W+1];
    logic [DEN_W-1:0]   div_den  [QUO_W+1];
    logic [QUO_W-1:0]   div_quo  [QUO_W+1];

    logic               tot_sign;
    logic signed [QUO_W:0] res;
    logic signed [QUO_W:0] res_sat;
    logic               done_reg;
    logic signed [15:0] noise_value_reg;

    // The pipeline takes a word every cycle, so it never pushes back.
    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            octave_count_reg <= OCTAVES_RST;
            persistence_reg  <= PERSIST_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_OCTAVES: octave_count_reg <= cfg_data[3:0];
                CFG_PERSIST: persistence_reg  <= cfg_data;
                default:     ;
            endcase
        end
    end

    // Effective octave count, clamped to one through MAX_OCTAVES.
    always_comb
    begin
        oc_wide = {1'b0, octave_count_reg};
        if (oc_wide == 5'd0)
            n_oct = CNT_W'(1);
        else if (oc_wide > 5'(MAX_OCTAVES))
            n_oct = CNT_W'(MAX_OCTAVES);
        else
            n_oct = CNT_W'(oc_wide);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else
            in_vld_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        cx_in_reg <= coord_x;
        cy_in_reg <= coord_y;
        cz_in_reg <= coord_z;
    end

    // The first octave starts with empty sums and amplitude 1.0.
    assign oct_vld[0]  = in_vld_reg;
    assign oct_cx[0]   = cx_in_reg;
    assign oct_cy[0]   = cy_in_reg;
    assign oct_cz[0]   = cz_in_reg;
    assign oct_tot[0]  = '0;
    assign oct_asum[0] = '0;
    assign oct_amp[0]  = AMP_W'(AMP_ONE);

    for (genvar k = 0; k < MAX_OCTAVES; k++)
    begin : g_oct
        gnos_octave_cell #(
            .MAX_OCTAVES   (MAX_OCTAVES),
            .FRACTION_BITS (FRACTION_BITS),
            .OCT           (k)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .n_oct       (n_oct),
            .persistence (persistence_reg),
            .in_valid    (oct_vld[k]),
            .in_cx       (oct_cx[k]),
            .in_cy       (oct_cy[k]),
            .in_cz       (oct_cz[k]),
            .in_total    (oct_tot[k]),
            .in_asum     (oct_asum[k]),
            .in_amp      (oct_amp[k]),
            .out_valid   (oct_vld[k+1]),
            .out_cx      (oct_cx[k+1]),
            .out_cy      (oct_cy[k+1]),
            .out_cz      (oct_cz[k+1]),
            .out_total   (oct_tot[k+1]),
            .out_asum    (oct_asum[k+1]),
            .out_amp     (oct_amp[k+1])
        );
    end

    // Floor division of a negative sum: divide the ones' complement, which
    // is -n - 1, and complement the quotient again at the end.
    assign tot_sign    = oct_tot[MAX_OCTAVES][TOT_W-1];
    assign div_vld[0]  = oct_vld[MAX_OCTAVES];
    assign div_sign[0] = tot_sign;
    assign div_rem[0]  = oct_tot[MAX_OCTAVES] ^ {TOT_W{tot_sign}};
    assign div_den[0]  = {oct_asum[MAX_OCTAVES], 2'b00};
    assign div_quo[0]  = '0;

    for (genvar j = 0; j < QUO_W; j++)
    begin : g_div
        gnos_div_cell #(
            .TOT_W (TOT_W),
            .DEN_W (DEN_W),
            .BIT   (QUO_W - 1 - j)
        ) u_div (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (div_vld[j]),
            .in_sign   (div_sign[j]),
            .in_rem    (div_rem[j]),
            .in_den    (div_den[j]),
            .in_quo    (div_quo[j]),
            .out_valid (div_vld[j+1]),
            .out_sign  (div_sign[j+1]),
            .out_rem   (div_rem[j+1]),
            .out_den   (div_den[j+1]),
            .out_quo   (div_quo[j+1])
        );
    end

    always_comb
    begin
        res = div_sign[QUO_W] ? ~{1'b0, div_quo[QUO_W]} : {1'b0, div_quo[QUO_W]};
        if (res > NOISE_MAX)
            res_sat = NOISE_MAX;
        else if (res < NOISE_MIN)
            res_sat = NOISE_MIN;
        else
            res_sat = res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= div_vld[QUO_W];
    end

    always_ff @(posedge clk)
    begin
        noise_value_reg <= res_sat[15:0];
    end

    assign done        = done_reg;
    assign noise_value = noise_value_reg;

    // Every result belongs to a word taken earlier with start high.
    a_done_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, TOTAL_LAT))
        else $error("result without a matching start");

    // The summed amplitude always includes the first octave's 1.0.
    a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        div_vld[0] |-> div_den[0] != '0)
        else $error("zero divisor reached the divider");

    // After the last step the remainder must be below the divisor, or the
    // quotient did not fit in its sixteen bits.
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        div_vld[QUO_W] |-> div_rem[QUO_W] < TOT_W'(div_den[QUO_W]))
        else $error("divider remainder out of range");

endmodule

`default_nettype wire

### rtl/core/gnos_octave_cell.sv
`timescale 1ns / 1ps
`default_nettype none

// One octave of gradient noise, sixteen stages deep. If OCT is below n_oct,
// the cell adds its weighted noise and its amplitude to the running sums; it
// hands the point, the sums and the next amplitude to the following cell.
module gnos_octave_cell #(
    parameter int MAX_OCTAVES   = 8,
    parameter int FRACTION_BITS = 16,
    parameter int OCT           = 0,
    localparam int AMP_W  = 16 + MAX_OCTAVES,
    localparam int ASUM_W = 17 + MAX_OCTAVES,
    localparam int TOT_W  = 36 + MAX_OCTAVES,
    localparam int CNT_W  = $clog2(MAX_OCTAVES + 1)
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [CNT_W-1:0]         n_oct,
    input  logic [15:0]              persistence,
    input  logic                     in_valid,
    input  logic signed [31:0]       in_cx,
    input  logic signed [31:0]       in_cy,
    input  logic signed [31:0]       in_cz,
    input  logic signed [TOT_W-1:0]  in_total,
    input  logic [ASUM_W-1:0]        in_asum,
    input  logic [AMP_W-1:0]         in_amp,
    output logic                     out_valid,
    output logic signed [31:0]       out_cx,
    output logic signed [31:0]       out_cy,
    output logic signed [31:0]       out_cz,
    output logic signed [TOT_W-1:0]  out_total,
    output logic [ASUM_W-1:0]        out_asum,
    output logic [AMP_W-1:0]         out_amp
);
    import gnos_pkg::*;

    localparam int SCL_W = 32 + MAX_OCTAVES;
    localparam int LAST  = CELL_LAT;

    // Coordinate split, combinational in front of stage one; qv feeds stage two.
    logic [31:0]              crd [3];
    logic [SCL_W-1:0]         scl [3];
    logic [FRACTION_BITS+15:0] fw [3];
    logic [7:0]               cix [3];
    logic [15:0]              t0 [3];
    logic [35:0]              qv [3];
    logic                     active;

    // Carry line for the word that rides along the cell.
    logic [LAST:1]            vld_reg;
    logic signed [31:0]       cx_reg [1:LAST];
    logic signed [31:0]       cy_reg [1:LAST];
    logic signed [31:0]       cz_reg [1:LAST];
    logic signed [TOT_W-1:0]  tot_reg [1:LAST-1];
    logic [ASUM_W-1:0]        asum_reg [1:LAST-1];
    logic [AMP_W-1:0]         amp_reg [1:LAST-1];
    logic [AMP_W+15:0]        ampp_reg;
    logic [AMP_W-1:0]         an_reg [2:LAST];

    // Datapath stages.
    logic [15:0]              t1_reg [3];
    logic [31:0]              tt1_reg [3];
    logic [8:0]               a1_reg;
    logic [8:0]               b1_reg;
    logic [7:0]               z1_reg;
    logic [15:0]              t2_reg [3];
    logic [19:0]              f0_reg [3];
    logic [8:0]               cb2_reg [4];
    logic [15:0]              t3_reg [3];
    logic [17:0]              f1_reg [3];
    logic [7:0]               h1_reg [8];
    logic [15:0]              t4_reg [3];
    logic [16:0]              f2_reg [3];
    logic [7:0]               h2_reg [8];
    logic [15:0]              t5_reg [3];
    logic [3:0]               h5_reg [8];
    logic [15:0]              fd_reg [5:10][3];
    logic signed [GRAD_W-1:0] g6_reg [8];
    logic signed [GRAD_W-1:0] a7_reg [4];
    logic signed [PROD_W-1:0] p7_reg [4];
    logic signed [GRAD_W-1:0] l8_reg [4];
    logic signed [GRAD_W-1:0] a9_reg [2];
    logic signed [PROD_W-1:0] p9_reg [2];
    logic signed [GRAD_W-1:0] m10_reg [2];
    logic signed [GRAD_W-1:0] a11_reg;
    logic signed [PROD_W-1:0] p11_reg;
    logic signed [GRAD_W-1:0] n12_reg;
    logic signed [SCL_PROD_W-1:0] s13_reg;
    logic signed [GRAD_W-1:0] nz14_reg;
    logic signed [TOT_W-1:0]  wt15_reg;
    logic signed [TOT_W-1:0]  out_total_reg;
    logic [ASUM_W-1:0]        out_asum_reg;

    assign crd[0] = in_cx;
    assign crd[1] = in_cy;
    assign crd[2] = in_cz;

    // The octave shift is wiring: take the cell index and the fraction from
    // the point scaled by two to the octave number.
    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            scl[a] = {{MAX_OCTAVES{1'b0}}, crd[a]} << OCT;
            cix[a] = scl[a][FRACTION_BITS+7 -: 8];
            fw[a]  = {scl[a][FRACTION_BITS-1:0], 16'h0000};
            t0[a]  = fw[a][FRACTION_BITS+15 -: 16];
            // 6t^2 - 15t + 10 in Q.32; the true value stays positive.
            qv[a]  = (36'd10 << 32) + 36'(tt1_reg[a]) * 36'd6
                   - ((36'(t1_reg[a]) * 36'd15) << 16);
        end
    end

    assign active = (CNT_W'(OCT) < n_oct);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[LAST-1:1], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        // Carry line.
        cx_reg[1]   <= in_cx;
        cy_reg[1]   <= in_cy;
        cz_reg[1]   <= in_cz;
        tot_reg[1]  <= in_total;
        asum_reg[1] <= in_asum;
        amp_reg[1]  <= in_amp;
        for (int k = 2; k <= LAST; k++)
        begin
            cx_reg[k] <= cx_reg[k-1];
            cy_reg[k] <= cy_reg[k-1];
            cz_reg[k] <= cz_reg[k-1];
        end
        for (int k = 2; k < LAST; k++)
        begin
            tot_reg[k]  <= tot_reg[k-1];
            asum_reg[k] <= asum_reg[k-1];
            amp_reg[k]  <= amp_reg[k-1];
        end
        ampp_reg  <= in_amp * persistence;
        an_reg[2] <= ampp_reg[15 +: AMP_W];
        for (int k = 3; k <= LAST; k++)
            an_reg[k] <= an_reg[k-1];

        // Stage 1: t squared, first hash level.
        for (int a = 0; a < 3; a++)
        begin
            t1_reg[a]  <= t0[a];
            tt1_reg[a] <= t0[a] * t0[a];
        end
        a1_reg <= {1'b0, PERM[cix[0]]} + {1'b0, cix[1]};
        b1_reg <= {1'b0, PERM[8'(cix[0] + 8'd1)]} + {1'b0, cix[1]};
        z1_reg <= cix[2];

        // Stage 2: fade polynomial, second hash level.
        for (int a = 0; a < 3; a++)
        begin
            t2_reg[a] <= t1_reg[a];
            f0_reg[a] <= qv[a][35:16];
        end
        cb2_reg[0] <= {1'b0, PERM[a1_reg[7:0]]} + {1'b0, z1_reg};
        cb2_reg[1] <= {1'b0, PERM[b1_reg[7:0]]} + {1'b0, z1_reg};
        cb2_reg[2] <= {1'b0, PERM[8'(a1_reg[7:0] + 8'd1)]} + {1'b0, z1_reg};
        cb2_reg[3] <= {1'b0, PERM[8'(b1_reg[7:0] + 8'd1)]} + {1'b0, z1_reg};

        // Stages 3 to 5: fade times t three times, triple lookup per corner.
        // The middle product t^2 * q peaks near 1.2, so it keeps 17 bits.
        for (int a = 0; a < 3; a++)
        begin
            t3_reg[a] <= t2_reg[a];
            f1_reg[a] <= 18'((36'(t2_reg[a]) * 36'(f0_reg[a])) >> 16);
            t4_reg[a] <= t3_reg[a];
            f2_reg[a] <= 17'((34'(t3_reg[a]) * 34'(f1_reg[a])) >> 16);
            t5_reg[a] <= t4_reg[a];
            fd_reg[5][a] <= 16'((33'(t4_reg[a]) * 33'(f2_reg[a])) >> 16);
        end
        for (int c = 0; c < 8; c++)
        begin
            h1_reg[c] <= PERM[8'(cb2_reg[c & 3] + 9'(c >> 2))];
            h2_reg[c] <= PERM[h1_reg[c]];
            h5_reg[c] <= PERM[h2_reg[c]][3:0];
        end

        for (int k = 6; k <= 10; k++)
            fd_reg[k] <= fd_reg[k-1];

        // Stage 6: gradient at each corner; bit 0 of the corner picks x or
        // x - 1, bit 1 y or y - 1, bit 2 z or z - 1.
        for (int c = 0; c < 8; c++)
        begin
            g6_reg[c] <= grad(h5_reg[c],
                (c & 1) != 0 ? $signed({2'b11, t5_reg[0]}) : $signed({2'b00, t5_reg[0]}),
                (c & 2) != 0 ? $signed({2'b11, t5_reg[1]}) : $signed({2'b00, t5_reg[1]}),
                (c & 4) != 0 ? $signed({2'b11, t5_reg[2]}) : $signed({2'b00, t5_reg[2]}));
        end

        // Stages 7 and 8: blend along x.
        for (int k = 0; k < 4; k++)
        begin
            a7_reg[k] <= g6_reg[2*k];
            p7_reg[k] <= (DIFF_W'(g6_reg[2*k+1]) - DIFF_W'(g6_reg[2*k]))
                       * $signed({1'b0, fd_reg[6][0]});
            l8_reg[k] <= a7_reg[k] + GRAD_W'(p7_reg[k] >>> 16);
        end

        // Stages 9 and 10: blend along y.
        for (int k = 0; k < 2; k++)
        begin
            a9_reg[k]  <= l8_reg[2*k];
            p9_reg[k]  <= (DIFF_W'(l8_reg[2*k+1]) - DIFF_W'(l8_reg[2*k]))
                        * $signed({1'b0, fd_reg[8][1]});
            m10_reg[k] <= a9_reg[k] + GRAD_W'(p9_reg[k] >>> 16);
        end

        // Stages 11 to 14: blend along z, then scale by 1.04.
        a11_reg  <= m10_reg[0];
        p11_reg  <= (DIFF_W'(m10_reg[1]) - DIFF_W'(m10_reg[0]))
                  * $signed({1'b0, fd_reg[10][2]});
        n12_reg  <= a11_reg + GRAD_W'(p11_reg >>> 16);
        s13_reg  <= n12_reg * $signed({1'b0, SCALE_Q16});
        nz14_reg <= GRAD_W'(s13_reg >>> 16);

        // Stage 15: weight by the amplitude; stage 16: accumulate.
        wt15_reg      <= nz14_reg * $signed({1'b0, amp_reg[LAST-2]});
        out_total_reg <= tot_reg[LAST-1] + (active ? wt15_reg : '0);
        out_asum_reg  <= asum_reg[LAST-1] + (active ? ASUM_W'(amp_reg[LAST-1]) : '0);
    end

    assign out_valid = vld_reg[LAST];
    assign out_cx    = cx_reg[LAST];
    assign out_cy    = cy_reg[LAST];
    assign out_cz    = cz_reg[LAST];
    assign out_total = out_total_reg;
    assign out_asum  = out_asum_reg;
    assign out_amp   = an_reg[LAST];

endmodule

`default_nettype wire

### rtl/core/gnos_div_cell.sv
`timescale 1ns / 1ps
`default_nettype none

// One restoring division step: decides quotient bit BIT and passes the
// partial remainder on.
module gnos_div_cell #(
    parameter int TOT_W = 44,
    parameter int DEN_W = 27,
    parameter int BIT   = 0
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         in_sign,
    input  logic [TOT_W-1:0]             in_rem,
    input  logic [DEN_W-1:0]             in_den,
    input  logic [gnos_pkg::QUO_W-1:0]   in_quo,
    output logic                         out_valid,
    output logic                         out_sign,
    output logic [TOT_W-1:0]             out_rem,
    output logic [DEN_W-1:0]             out_den,
    output logic [gnos_pkg::QUO_W-1:0]   out_quo
);
    import gnos_pkg::*;

    localparam int EXT_W = TOT_W + 1;

    logic [EXT_W-1:0]  trial;
    logic              valid_reg;
    logic              sign_reg;
    logic [TOT_W-1:0]  rem_reg;
    logic [TOT_W-1:0]  rem_next;
    logic [DEN_W-1:0]  den_reg;
    logic [QUO_W-1:0]  quo_reg;
    logic [QUO_W-1:0]  quo_next;

    always_comb
    begin
        trial    = {1'b0, in_rem} - (EXT_W'(in_den) << BIT);
        rem_next = in_rem;
        quo_next = in_quo;
        if (!trial[TOT_W])
        begin
            rem_next      = trial[TOT_W-1:0];
            quo_next[BIT] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        sign_reg <= in_sign;
        rem_reg  <= rem_next;
        den_reg  <= in_den;
        quo_reg  <= quo_next;
    end

    assign out_valid = valid_reg;
    assign out_sign  = sign_reg;
    assign out_rem   = rem_reg;
    assign out_den   = den_reg;
    assign out_quo   = quo_reg;

endmodule

`default_nettype wire

### bench/tb_gradient_noise_octave_sum.sv
`timescale 1ns / 1ps

module tb_gradient_noise_octave_sum;
    import gnos_pkg::*;

    // Register indexes past the two real registers; the block must ignore them.
    localparam logic [1:0] CFG_SPARE_A = 2'd2;
    localparam logic [1:0] CFG_SPARE_B = 2'd3;

    // Pipeline depth of the block at its default of eight octaves.
    localparam int PIPE_LAT = 18 + 16 * 8;
    // Cycles without a word, result or config write before a hang is declared.
    localparam int STALL_LIMIT = 4 * (PIPE_LAT + 100);

    typedef enum logic [1:0] {
        ENTRY_POINT,
        ENTRY_CFG,
        ENTRY_DRAIN
    } entry_kind_e;

    typedef struct {
        entry_kind_e        kind;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic [1:0]         idx;
        logic [15:0]        data;
    } entry_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
    logic               done;
    logic signed [15:0] noise_value;
    logic               cfg_we;
    logic [1:0]         cfg_index;
    logic [15:0]        cfg_data;

    gradient_noise_octave_sum dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .coord_x    (coord_x),
        .coord_y    (coord_y),
        .coord_z    (coord_z),
        .done       (done),
        .noise_value(noise_value),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    // Pending stimulus, filled once by the initial block below.
    entry_t pending_entries[$];
    // Noise values still owed by the block, oldest first.
    logic signed [15:0] owed_noise[$];

    // Our own copy of the two configuration registers.
    logic [3:0]  octaves_shadow;
    logic [15:0] persist_shadow;

    int  error_count;
    int  idle_cycles;
    int  gap_left;
    int  calm_left;
    bit  stimulus_done;
    logic word_taken;

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // ---------------------------------------------------------------------
    // Noise predictor. All arithmetic is done in 64-bit signed integers,
    // which is wide enough for every intermediate of eight octaves.
    // ---------------------------------------------------------------------

    // Quintic fade curve on a Q0.16 fraction, truncating after each product.
    function automatic longint fade_q16(longint t);
        longint q;
        longint f;
        q = 6 * t * t - 15 * t * 65536 + (longint'(10) <<< 32);
        f = q >>> 16;
        f = (t * f) >>> 16;
        f = (t * f) >>> 16;
        f = (t * f) >>> 16;
        return f;
    endfunction

    // Linear blend; the arithmetic shift floors negative products.
    function automatic longint mix_q16(longint a, longint b, longint w);
        return a + (((b - a) * w) >>> 16);
    endfunction

    // The triple permutation lookup selects one of the edge gradients.
    function automatic longint corner_dot(int idx, longint x, longint y, longint z);
        logic [3:0] h;
        longint     u;
        longint     v;
        h = PERM[PERM[PERM[idx & 255]]][3:0];
        u = (h < 8) ? x : y;
        if (h < 4)
            v = y;
        else if (h == 12 || h == 14)
            v = x;
        else
            v = z;
        if (h[0])
            u = -u;
        if (h[1])
            v = -v;
        return u + v;
    endfunction

    // One octave of gradient noise at the point scaled by 2^oct, in Q.16.
    function automatic longint octave_noise(logic signed [31:0] cx, logic signed [31:0] cy,
                                            logic signed [31:0] cz, int oct);
        logic [63:0] sx;
        logic [63:0] sy;
        logic [63:0] sz;
        int          ix, iy, iz, a, b, aa, ab, ba, bb;
        longint      fx, fy, fz, u, v, w, x1, y1, z1, l1, l2, l3, l4, m1, m2;
        // Scaling is done in wide two's complement so the cell index wraps.
        sx = 64'(longint'(cx)) << oct;
        sy = 64'(longint'(cy)) << oct;
        sz = 64'(longint'(cz)) << oct;
        ix = sx[23:16];
        iy = sy[23:16];
        iz = sz[23:16];
        fx = sx[15:0];
        fy = sy[15:0];
        fz = sz[15:0];
        u  = fade_q16(fx);
        v  = fade_q16(fy);
        w  = fade_q16(fz);
        x1 = fx - 65536;
        y1 = fy - 65536;
        z1 = fz - 65536;
        a  = PERM[ix] + iy;
        aa = PERM[a & 255] + iz;
        ab = PERM[(a + 1) & 255] + iz;
        b  = PERM[(ix + 1) & 255] + iy;
        ba = PERM[b & 255] + iz;
        bb = PERM[(b + 1) & 255] + iz;
        l1 = mix_q16(corner_dot(aa, fx, fy, fz), corner_dot(ba, x1, fy, fz), u);
        l2 = mix_q16(corner_dot(ab, fx, y1, fz), corner_dot(bb, x1, y1, fz), u);
        m1 = mix_q16(l1, l2, v);
        l3 = mix_q16(corner_dot(aa + 1, fx, fy, z1), corner_dot(ba + 1, x1, fy, z1), u);
        l4 = mix_q16(corner_dot(ab + 1, fx, y1, z1), corner_dot(bb + 1, x1, y1, z1), u);
        m2 = mix_q16(l3, l4, v);
        return (mix_q16(m1, m2, w) * longint'(SCALE_Q16)) >>> 16;
    endfunction

    // Amplitude-weighted octave sum, normalized and saturated to Q2.14.
    function automatic logic signed [15:0] fbm_noise(logic signed [31:0] cx,
                                                     logic signed [31:0] cy,
                                                     logic signed [31:0] cz);
        int     n;
        longint amp;
        longint amp_sum;
        longint total;
        longint d;
        longint r;
        n = octaves_shadow;
        if (n == 0)
            n = 1;
        if (n > 8)
            n = 8;
        amp = 32768;
        amp_sum = 0;
        total = 0;
        for (int i = 0; i < n; i++)
        begin
            total += octave_noise(cx, cy, cz, i) * amp;
            amp_sum += amp;
            amp = (amp * longint'(persist_shadow)) >>> 15;
        end
        d = amp_sum * 4;
        if (total >= 0)
            r = total / d;
        else
            r = -((-(total + 1)) / d) - 1;
        if (r > 32767)
            r = 32767;
        if (r < -32768)
            r = -32768;
        return r[15:0];
    endfunction

    task automatic report_mismatch(string what, longint want, longint got);
        $display("mismatch at %0t: %s, expected %0d, got %0d", $time, what, want, got);
        error_count++;
    endtask

    // ---------------------------------------------------------------------
    // Stimulus construction.
    // ---------------------------------------------------------------------

    task automatic add_point(logic signed [31:0] x, logic signed [31:0] y,
                             logic signed [31:0] z);
        entry_t e;
        e.kind = ENTRY_POINT;
        e.x = x;
        e.y = y;
        e.z = z;
        e.idx = CFG_OCTAVES;
        e.data = '0;
        pending_entries.push_back(e);
    endtask

    task automatic add_cfg(logic [1:0] idx, logic [15:0] data);
        entry_t e;
        e.kind = ENTRY_CFG;
        e.x = '0;
        e.y = '0;
        e.z = '0;
        e.idx = idx;
        e.data = data;
        pending_entries.push_back(e);
    endtask

    task automatic add_drain();
        entry_t e;
        e.kind = ENTRY_DRAIN;
        e.x = '0;
        e.y = '0;
        e.z = '0;
        e.idx = CFG_OCTAVES;
        e.data = '0;
        pending_entries.push_back(e);
    endtask

    // Half of the coordinates span the full range, the rest stay near the
    // origin where neighboring cells and octaves overlap.
    function automatic logic signed [31:0] pick_coord();
        if ($urandom_range(0, 1))
            return $urandom;
        return $signed($urandom_range(0, 32'h003F_FFFF)) - 32'sh0020_0000;
    endfunction

    initial
    begin
        logic [15:0] octave_set[8];
        logic [15:0] persist_set[8];

        // Directed points under the reset configuration: plain single noise.
        add_point(32'sd0, 32'sd0, 32'sd0);
        add_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        add_point(-32'sh8000_0000, -32'sh8000_0000, -32'sh8000_0000);
        add_point(-32'sd1, -32'sd1, -32'sd1);
        add_point(32'sh0000_FFFF, 32'sh0001_0000, 32'sh0000_8000);
        add_point(32'sh0001_8000, 32'sh0000_0000, 32'sh0000_0000);
        add_point(32'sh0000_4000, 32'sh0000_C000, 32'sd0);
        add_point(32'sh00FF_FFFF, -32'sh0000_8000, 32'sh0100_0001);
        add_point(32'sh5555_5555, 32'shAAAA_AAAA, 32'sh0F0F_F0F0);

        // All eight octaves, persistence just under 2.0 in Q1.15: coordinates
        // wrap on scaling and the highest octaves dominate the sum.
        add_drain();
        add_cfg(CFG_OCTAVES, 16'd8);
        add_cfg(CFG_PERSIST, 16'd65535);
        add_point(32'sh7FFF_FFFF, 32'sh0000_0001, -32'sh8000_0000);
        add_point(32'sh4000_C000, 32'sh1234_5678, -32'sh2345_6789);
        add_point(32'sh0000_8000, 32'sh0000_8000, 32'sh0000_8000);

        // Zero persistence leaves only the first octave, and an octave count
        // above the maximum is clamped. Writes to spare indexes go nowhere.
        add_cfg(CFG_PERSIST, 16'd0);
        add_cfg(CFG_OCTAVES, 16'd15);
        add_cfg(CFG_SPARE_A, 16'hFFFF);
        add_cfg(CFG_SPARE_B, 16'h0000);
        add_point(32'sh0003_7000, -32'sh0001_1000, 32'sh0000_0100);
        add_point(-32'sh7FFF_0000, 32'sh7FFF_0000, 32'sh0000_FFFF);

        // A zero octave count acts as one.
        add_cfg(CFG_OCTAVES, 16'd0);
        add_cfg(CFG_PERSIST, 16'd32768);
        add_point(32'sh0002_A000, 32'sh0001_5000, -32'sh0003_3000);
        add_point(32'sh0000_0001, 32'sh0000_0001, 32'sh0000_0001);

        // Random phases, each under its own configuration. A drain before
        // each phase keeps configuration writes away from words in flight.
        octave_set  = '{16'd1, 16'd8, 16'd3, 16'd0, 16'd12, 16'd5, 16'd2, 16'd7};
        persist_set = '{16'd65535, 16'd0, 16'd16384, 16'd40000, 16'd1, 16'd49152,
                        16'd8192, 16'd30000};
        for (int p = 0; p < 8; p++)
        begin
            add_drain();
            add_cfg(CFG_OCTAVES, (p == 6) ? 16'($urandom_range(0, 15)) : octave_set[p]);
            add_cfg(CFG_PERSIST, (p == 7) ? 16'($urandom) : persist_set[p]);
            if (p == 3)
                add_cfg(CFG_SPARE_A, 16'($urandom));
            for (int k = 0; k < 175; k++)
                add_point(pick_coord(), pick_coord(), pick_coord());
        end
    end

    // ---------------------------------------------------------------------
    // Reset, then driver and monitor.
    // ---------------------------------------------------------------------

    initial
    begin
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // The driver works on the falling edge. A word stays on the ports until
    // the monitor has seen it taken; a configuration write or a drain waits
    // until every owed noise value has arrived.
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start          <= 1'b0;
            coord_x        <= '0;
            coord_y        <= '0;
            coord_z        <= '0;
            cfg_we         <= 1'b0;
            cfg_index      <= CFG_OCTAVES;
            cfg_data       <= '0;
            octaves_shadow <= OCTAVES_RST;
            persist_shadow <= PERSIST_RST;
            gap_left       <= 0;
            calm_left      <= 0;
            stimulus_done  <= 1'b0;
        end
        else
        begin : drive
            entry_t e;
            logic   next_start;
            logic   next_we;
            int     r;
            next_start = 1'b0;
            next_we    = 1'b0;
            if (start && !word_taken)
                next_start = 1'b1;
            else if (gap_left > 0)
                gap_left <= gap_left - 1;
            else if (pending_entries.size() == 0)
                stimulus_done <= 1'b1;
            else if (pending_entries[0].kind == ENTRY_POINT)
            begin
                e = pending_entries.pop_front();
                coord_x <= e.x;
                coord_y <= e.y;
                coord_z <= e.z;
                next_start = 1'b1;
                // Stretches of back-to-back words alternate with gaps that
                // are mostly short and now and then long.
                if (calm_left > 0)
                begin
                    calm_left <= calm_left - 1;
                    gap_left <= 0;
                end
                else
                begin
                    r = $urandom_range(0, 99);
                    if (r < 5)
                        calm_left <= $urandom_range(10, 60);
                    if (r < 50)
                        gap_left <= 0;
                    else if (r < 90)
                        gap_left <= $urandom_range(1, 3);
                    else
                        gap_left <= $urandom_range(10, 60);
                end
            end
            else if (owed_noise.size() == 0 && !start)
            begin
                e = pending_entries.pop_front();
                if (e.kind == ENTRY_CFG)
                begin
                    next_we    = 1'b1;
                    cfg_index <= e.idx;
                    cfg_data  <= e.data;
                    if (e.idx == CFG_OCTAVES)
                        octaves_shadow <= e.data[3:0];
                    else if (e.idx == CFG_PERSIST)
                        persist_shadow <= e.data;
                end
            end
            start  <= next_start;
            cfg_we <= next_we;
        end
    end

    // The monitor samples on the rising edge. An accepted word gets its
    // expected noise value predicted under the configuration in force now;
    // every done word is checked against the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_taken  <= 1'b0;
            idle_cycles <= 0;
        end
        else
        begin
            word_taken <= start && !busy;
            if (start && !busy)
                owed_noise.push_back(fbm_noise(coord_x, coord_y, coord_z));
            if (done)
            begin
                if (owed_noise.size() == 0)
                    report_mismatch("noise_value with nothing owed", 0, noise_value);
                else
                begin : check
                    logic signed [15:0] want;
                    want = owed_noise.pop_front();
                    if (noise_value !== want)
                        report_mismatch("noise_value", want, noise_value);
                end
            end
            if ((start && !busy) || done || cfg_we)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // End of run: all words sent, nothing owed, then a quiet tail to catch
    // any stray result.
    initial
    begin
        error_count = 0;
        wait (rst_n === 1'b1);
        wait (stimulus_done && !start && owed_noise.size() == 0);
        repeat (PIPE_LAT + 20) @(posedge clk);
        if (owed_noise.size() != 0)
            report_mismatch("noise values never delivered", 0, owed_noise.size());
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
